>>> hdl/epr_pkg.sv
// Shared types and constants for the echo pulse ranger.
// Used by echo_pulse_ranger_top; depends on nothing.
package epr_pkg;

	localparam int SENSORS = 4;
	localparam int ADDR_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam int SENSOR_W = 2;
	localparam int TS_W = 16;
	localparam int SCALE_W = 10;
	localparam int DIST_W = 14;
	localparam int MISS_W = 3;
	localparam int PROD_W = TS_W + SCALE_W;
	localparam int FRAC_W = 10;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [SCALE_W-1:0] SCALE_RST = 10'd281;
	localparam logic [DIST_W-1:0] RANGE_RST = 14'd6400;
	localparam logic [MISS_W-1:0] MISS_RST = 3'd4;
	localparam logic [DIST_W-1:0] NO_OBJ_RST = 14'd15984;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_FACTOR = 2'd0,
		REG_RANGE_LIMIT = 2'd1,
		REG_MISS_LIMIT = 2'd2,
		REG_NO_OBJECT_VALUE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [TS_W-1:0] start_time;
		logic start_valid;
	} start_ent_t;

	typedef struct packed {
		logic [MISS_W-1:0] miss_count;
		logic [DIST_W-1:0] stored_distance;
	} track_ent_t;

endpackage

>>> hdl/echo_pulse_ranger_top.sv
// Echo pulse ranger top level: edge events in, per-sensor distance updates out.
// Depends on epr_pkg.
//
// Each edge transaction on the slave side names a sensor, its polarity and a 16-bit
// microsecond timestamp. A rising edge records the pulse start; a falling edge after a
// recorded start measures the modular 16-bit width, multiplies it by scale_factor and
// drops 10 fraction bits to get a reading in 1/16 cm, updates the sensor's miss count and
// stored distance, and emits one transaction with the stored distance. Other edges emit
// nothing. One edge is taken every cycle while the output is not stalled; each result passes
// stage 1 (start-time memory read, multiply), stage 2 (tracking-memory read-modify-write)
// and the output register. Per-sensor state sits in two small memories, with the most
// recent write forwarded to the following access; no clearing pass is needed after reset.
// Configuration writes are taken at any time and must only be issued while the block is idle.
module echo_pulse_ranger_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [epr_pkg::IN_DATA_W-1:0] s_tdata, // sensor[1:0], timestamp[17:2], zeros
	input  logic s_tuser, // rising
	output logic m_tvalid,
	input  logic m_tready,
	output logic [epr_pkg::OUT_DATA_W-1:0] m_tdata, // which_sensor[1:0], distance[15:2]
	output logic [epr_pkg::OUT_USER_W-1:0] m_tuser, // in_range[0], no_object[1]
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [epr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [epr_pkg::DIST_W-1:0] cfg_data
);

	logic [epr_pkg::SCALE_W-1:0] scale_q;
	logic [epr_pkg::DIST_W-1:0] range_q;
	logic [epr_pkg::MISS_W-1:0] miss_lim_q;
	logic [epr_pkg::DIST_W-1:0] no_obj_q;

	epr_pkg::start_ent_t t_mem [epr_pkg::SENSORS];
	epr_pkg::start_ent_t t_rd_q;
	logic [epr_pkg::SENSORS-1:0] t_vld_q;
	logic t_rdv_q;
	logic [epr_pkg::ADDR_W-1:0] t_raddr;
	logic t_we;
	epr_pkg::start_ent_t t_wdata;
	epr_pkg::start_ent_t wt_q;
	logic [epr_pkg::ADDR_W-1:0] wt_addr_q;
	logic wt_vld_q;

	epr_pkg::track_ent_t m_mem [epr_pkg::SENSORS];
	epr_pkg::track_ent_t m_rd_q;
	logic [epr_pkg::SENSORS-1:0] m_vld_q;
	logic m_rdv_q;
	logic [epr_pkg::ADDR_W-1:0] m_raddr;
	logic m_we;
	epr_pkg::track_ent_t m_wdata;
	epr_pkg::track_ent_t wm_q;
	logic [epr_pkg::ADDR_W-1:0] wm_addr_q;
	logic wm_vld_q;

	logic v_s1;
	logic [epr_pkg::SENSOR_W-1:0] sensor_s1;
	logic rising_s1;
	logic [epr_pkg::TS_W-1:0] ts_s1;

	logic v_s2;
	logic [epr_pkg::SENSOR_W-1:0] sensor_s2;
	logic [epr_pkg::PROD_W-1:0] prod_s2;

	logic out_v_q;
	logic [epr_pkg::SENSOR_W-1:0] out_sensor_q;
	logic [epr_pkg::DIST_W-1:0] out_dist_q;
	logic out_hit_q;
	logic out_noobj_q;

	logic out_free, s2_open, s2_go, s1_go, s1_open;
	logic ok_s1, fire_s1;
	epr_pkg::start_ent_t st_s1;
	logic [epr_pkg::TS_W-1:0] width_s1;
	logic [epr_pkg::PROD_W-1:0] prod_s1;

	epr_pkg::track_ent_t tr_s2;
	logic [epr_pkg::TS_W-1:0] reading_s2;
	logic hit_s2, sat_s2;
	logic [epr_pkg::MISS_W-1:0] lim_s2, miss_inc_s2, miss_new_s2;
	logic [epr_pkg::DIST_W-1:0] dist_new_s2;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= epr_pkg::SCALE_RST;
			range_q <= epr_pkg::RANGE_RST;
			miss_lim_q <= epr_pkg::MISS_RST;
			no_obj_q <= epr_pkg::NO_OBJ_RST;
		end else if (cfg_valid) begin
			unique case (epr_pkg::cfg_reg_t'(cfg_index))
				epr_pkg::REG_SCALE_FACTOR: scale_q <= cfg_data[epr_pkg::SCALE_W-1:0];
				epr_pkg::REG_RANGE_LIMIT: range_q <= cfg_data;
				epr_pkg::REG_MISS_LIMIT: miss_lim_q <= cfg_data[epr_pkg::MISS_W-1:0];
				epr_pkg::REG_NO_OBJECT_VALUE: no_obj_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control
	assign out_free = !out_v_q || m_tready;
	assign s2_go = v_s2 && out_free;
	assign s2_open = !v_s2 || out_free;
	assign s1_go = v_s1 && (!fire_s1 || s2_open);
	assign s1_open = !v_s1 || s1_go;
	assign s_tready = s1_open;

	// stage 1: start-time lookup, width and scaling
	assign ok_s1 = 32'(sensor_s1) < epr_pkg::SENSORS;

	always_comb begin
		if (wt_vld_q && wt_addr_q == sensor_s1[epr_pkg::ADDR_W-1:0]) begin
			st_s1 = wt_q;
		end else if (t_rdv_q) begin
			st_s1 = t_rd_q;
		end else begin
			st_s1 = '0;
		end
	end

	assign fire_s1 = ok_s1 && !rising_s1 && st_s1.start_valid;
	assign width_s1 = ts_s1 - st_s1.start_time;
	assign prod_s1 = epr_pkg::PROD_W'(width_s1) * epr_pkg::PROD_W'(scale_q);

	assign t_raddr = s1_open ? s_tdata[epr_pkg::ADDR_W-1:0]
		: sensor_s1[epr_pkg::ADDR_W-1:0];
	assign t_we = s1_go && ok_s1 && (rising_s1 || fire_s1);
	assign t_wdata = rising_s1 ? epr_pkg::start_ent_t'{start_time: ts_s1, start_valid: 1'b1}
		: epr_pkg::start_ent_t'{start_time: st_s1.start_time, start_valid: 1'b0};

	always_ff @(posedge clk) begin
		if (t_we) begin
			t_mem[sensor_s1[epr_pkg::ADDR_W-1:0]] <= t_wdata;
		end
		t_rd_q <= t_mem[t_raddr];
		wt_q <= t_wdata;
		wt_addr_q <= sensor_s1[epr_pkg::ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_vld_q <= '0;
			t_rdv_q <= 1'b0;
			wt_vld_q <= 1'b0;
		end else begin
			if (t_we) begin
				t_vld_q[sensor_s1[epr_pkg::ADDR_W-1:0]] <= 1'b1;
			end
			t_rdv_q <= t_vld_q[t_raddr];
			wt_vld_q <= t_we;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_open) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_open) begin
			sensor_s1 <= s_tdata[epr_pkg::SENSOR_W-1:0];
			rising_s1 <= s_tuser;
			ts_s1 <= s_tdata[epr_pkg::SENSOR_W +: epr_pkg::TS_W];
		end
	end

	// stage 2: range check and miss tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_open) begin
			v_s2 <= s1_go && fire_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_open) begin
			sensor_s2 <= sensor_s1;
			prod_s2 <= prod_s1;
		end
	end

	assign m_raddr = s2_open ? sensor_s1[epr_pkg::ADDR_W-1:0]
		: sensor_s2[epr_pkg::ADDR_W-1:0];

	always_comb begin
		if (wm_vld_q && wm_addr_q == sensor_s2[epr_pkg::ADDR_W-1:0]) begin
			tr_s2 = wm_q;
		end else if (m_rdv_q) begin
			tr_s2 = m_rd_q;
		end else begin
			tr_s2 = '0;
		end
	end

	assign reading_s2 = prod_s2[epr_pkg::FRAC_W +: epr_pkg::TS_W];
	assign hit_s2 = reading_s2 < epr_pkg::TS_W'(range_q);
	assign lim_s2 = (miss_lim_q == '0) ? epr_pkg::MISS_W'(1) : miss_lim_q;
	assign miss_inc_s2 = (tr_s2.miss_count < lim_s2) ? tr_s2.miss_count + epr_pkg::MISS_W'(1)
		: tr_s2.miss_count;
	assign sat_s2 = !hit_s2 && miss_inc_s2 >= lim_s2;

	always_comb begin
		priority if (hit_s2) begin
			miss_new_s2 = '0;
			dist_new_s2 = reading_s2[epr_pkg::DIST_W-1:0];
		end else if (sat_s2) begin
			miss_new_s2 = lim_s2;
			dist_new_s2 = no_obj_q;
		end else begin
			miss_new_s2 = miss_inc_s2;
			dist_new_s2 = tr_s2.stored_distance;
		end
	end

	assign m_we = s2_go;
	assign m_wdata = '{miss_count: miss_new_s2, stored_distance: dist_new_s2};

	always_ff @(posedge clk) begin
		if (m_we) begin
			m_mem[sensor_s2[epr_pkg::ADDR_W-1:0]] <= m_wdata;
		end
		m_rd_q <= m_mem[m_raddr];
		wm_q <= m_wdata;
		wm_addr_q <= sensor_s2[epr_pkg::ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= '0;
			m_rdv_q <= 1'b0;
			wm_vld_q <= 1'b0;
		end else begin
			if (m_we) begin
				m_vld_q[sensor_s2[epr_pkg::ADDR_W-1:0]] <= 1'b1;
			end
			m_rdv_q <= m_vld_q[m_raddr];
			wm_vld_q <= m_we;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			out_sensor_q <= sensor_s2;
			out_dist_q <= dist_new_s2;
			out_hit_q <= hit_s2;
			out_noobj_q <= miss_new_s2 >= lim_s2;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {out_dist_q, out_sensor_q};
	assign m_tuser = {out_noobj_q, out_hit_q};

	a_hit_not_noobj: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("in_range and no_object both set");

	a_hit_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[epr_pkg::OUT_DATA_W-1:epr_pkg::SENSOR_W] < range_q)
		else $error("in-range distance at or above limit");

	a_noobj_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[epr_pkg::OUT_DATA_W-1:epr_pkg::SENSOR_W] == no_obj_q)
		else $error("no_object result without no-object distance");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_free |=> v_s2 && $stable(sensor_s2) && $stable(prod_s2))
		else $error("stalled stage 2 item lost");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted transaction not in stage 1");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for echo_pulse_ranger_top: edge transactions in, range results out.
// Depends on epr_pkg and the echo_pulse_ranger_top RTL; expected results come from an
// in-bench tracker of per-sensor start times, miss counts and stored distances.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		logic [epr_pkg::SENSOR_W-1:0] sensor;
		logic [epr_pkg::DIST_W-1:0] distance;
		logic in_range;
		logic no_object;
	} range_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [epr_pkg::IN_DATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [epr_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [epr_pkg::OUT_USER_W-1:0] m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [epr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [epr_pkg::DIST_W-1:0] cfg_data;

	logic [epr_pkg::TS_W-1:0] start_ts [epr_pkg::SENSORS];
	logic start_open [epr_pkg::SENSORS];
	logic [epr_pkg::MISS_W-1:0] miss_run [epr_pkg::SENSORS];
	logic [epr_pkg::DIST_W-1:0] held_dist [epr_pkg::SENSORS];
	logic [epr_pkg::SCALE_W-1:0] cur_scale;
	logic [epr_pkg::DIST_W-1:0] cur_range;
	logic [epr_pkg::MISS_W-1:0] cur_miss_limit;
	logic [epr_pkg::DIST_W-1:0] cur_no_obj;

	range_result_t pending_ranges [$];
	int errors;
	int edges_sent;
	int ranges_seen;
	int reg_writes;
	int hits_seen;
	int no_obj_seen;
	int burst_left;
	bit tx_gaps;
	rx_mode_t rx_mode;
	int rx_hold_left;
	logic [epr_pkg::SENSOR_W-1:0] last_sensor;

	echo_pulse_ranger_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("[echo_pulse_ranger_top] ERROR");
		$finish;
	end

	function automatic void track_edge(input logic [epr_pkg::SENSOR_W-1:0] sn, input logic rs,
			input logic [epr_pkg::TS_W-1:0] ts);
		logic [epr_pkg::TS_W-1:0] pw;
		logic [epr_pkg::PROD_W-1:0] prod;
		logic [epr_pkg::TS_W-1:0] reading;
		logic [epr_pkg::MISS_W-1:0] lim;
		logic [epr_pkg::MISS_W-1:0] miss;
		logic hit;
		range_result_t r;
		if (rs) begin
			start_ts[sn] = ts;
			start_open[sn] = 1'b1;
			return;
		end
		if (!start_open[sn])
			return;
		start_open[sn] = 1'b0;
		pw = ts - start_ts[sn];
		prod = epr_pkg::PROD_W'(pw) * epr_pkg::PROD_W'(cur_scale);
		reading = prod[epr_pkg::PROD_W-1:epr_pkg::FRAC_W];
		lim = (cur_miss_limit == '0) ? epr_pkg::MISS_W'(1) : cur_miss_limit;
		miss = miss_run[sn];
		hit = reading < epr_pkg::TS_W'(cur_range);
		if (hit) begin
			held_dist[sn] = reading[epr_pkg::DIST_W-1:0];
			miss = '0;
		end else begin
			if (miss < lim)
				miss = miss + epr_pkg::MISS_W'(1);
			if (miss >= lim) begin
				miss = lim;
				held_dist[sn] = cur_no_obj;
			end
		end
		miss_run[sn] = miss;
		r.sensor = sn;
		r.distance = held_dist[sn];
		r.in_range = hit;
		r.no_object = (miss >= lim);
		pending_ranges.push_back(r);
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin
		range_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			ranges_seen++;
			if (m_tuser[0])
				hits_seen++;
			if (m_tuser[1])
				no_obj_seen++;
			if (pending_ranges.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual sensor %0d distance %0d",
					$time, m_tdata[epr_pkg::SENSOR_W-1:0],
					m_tdata[epr_pkg::OUT_DATA_W-1:epr_pkg::SENSOR_W]);
			end else begin
				want = pending_ranges.pop_front();
				check_field("which_sensor", 32'(want.sensor),
					32'(m_tdata[epr_pkg::SENSOR_W-1:0]));
				check_field("distance", 32'(want.distance),
					32'(m_tdata[epr_pkg::OUT_DATA_W-1:epr_pkg::SENSOR_W]));
				check_field("in_range", 32'(want.in_range), 32'(m_tuser[0]));
				check_field("no_object", 32'(want.no_object), 32'(m_tuser[1]));
			end
		end
	end

	initial begin
		int rx_tick;
		rx_tick = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_tick++;
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else begin
				unique case (rx_mode)
					RX_STEADY: m_tready <= 1'b1;
					RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
					RX_PERIODIC: m_tready <= ((rx_tick % 7) < 4);
				endcase
			end
		end
	end

	task automatic send_edge(input logic [epr_pkg::SENSOR_W-1:0] sn, input logic rs,
			input logic [epr_pkg::TS_W-1:0] ts);
		int gap;
		if (tx_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(epr_pkg::IN_DATA_W - epr_pkg::TS_W - epr_pkg::SENSOR_W){1'b0}}, ts, sn};
		s_tuser <= rs;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_edge(sn, rs, ts);
		last_sensor = sn;
		edges_sent++;
	endtask

	task automatic send_pulse(input logic [epr_pkg::SENSOR_W-1:0] sn,
			input logic [epr_pkg::TS_W-1:0] t0, input logic [epr_pkg::TS_W-1:0] w);
		send_edge(sn, 1'b1, t0);
		send_edge(sn, 1'b0, t0 + w);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_ranges.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input epr_pkg::cfg_reg_t idx, input logic [epr_pkg::DIST_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		unique case (idx)
			epr_pkg::REG_SCALE_FACTOR: cur_scale = val[epr_pkg::SCALE_W-1:0];
			epr_pkg::REG_RANGE_LIMIT: cur_range = val;
			epr_pkg::REG_MISS_LIMIT: cur_miss_limit = val[epr_pkg::MISS_W-1:0];
			epr_pkg::REG_NO_OBJECT_VALUE: cur_no_obj = val;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	task automatic apply_settings(input int scale, input int lim_range, input int miss_lim,
			input int no_obj);
		wait_idle();
		write_reg(epr_pkg::REG_SCALE_FACTOR,
			{(epr_pkg::DIST_W - epr_pkg::SCALE_W)'($urandom), epr_pkg::SCALE_W'(scale)});
		write_reg(epr_pkg::REG_RANGE_LIMIT, epr_pkg::DIST_W'(lim_range));
		write_reg(epr_pkg::REG_MISS_LIMIT,
			{(epr_pkg::DIST_W - epr_pkg::MISS_W)'($urandom), epr_pkg::MISS_W'(miss_lim)});
		write_reg(epr_pkg::REG_NO_OBJECT_VALUE, epr_pkg::DIST_W'(no_obj));
	endtask

	function automatic int pulse_width();
		int thr;
		int hi;
		if (cur_scale == '0)
			return $urandom_range(0, 65535);
		thr = (int'(cur_range) << epr_pkg::FRAC_W) / int'(cur_scale);
		hi = (2 * thr + 16 > 65535) ? 65535 : 2 * thr + 16;
		unique case ($urandom_range(0, 3))
			0: return $urandom_range(0, 65535);
			3: return (thr + 2 > 65535) ? 65535 : $urandom_range((thr > 2) ? thr - 2 : 0, thr + 2);
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	task automatic random_edge();
		logic [epr_pkg::SENSOR_W-1:0] sn;
		logic [epr_pkg::TS_W-1:0] t_end;
		int kind;
		sn = ($urandom_range(0, 3) == 0) ? last_sensor : epr_pkg::SENSOR_W'($urandom);
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			send_edge(sn, 1'b0, epr_pkg::TS_W'($urandom));
		end else if (kind == 1 || !start_open[sn]) begin
			send_edge(sn, 1'b1, epr_pkg::TS_W'($urandom));
		end else begin
			t_end = start_ts[sn] + epr_pkg::TS_W'(pulse_width());
			send_edge(sn, 1'b0, t_end);
		end
	endtask

	task automatic test_directed_edges();
		tx_gaps = 0;
		rx_mode = RX_STEADY;
		send_edge(2'd0, 1'b0, 16'd1234);
		send_pulse(2'd0, 16'h0000, 16'd0);
		send_pulse(2'd1, 16'hFFF0, 16'd32);
		send_pulse(2'd2, 16'h0000, 16'hFFFF);
		send_edge(2'd3, 1'b1, 16'd100);
		send_edge(2'd3, 1'b1, 16'd5000);
		send_edge(2'd3, 1'b0, 16'd5500);
		send_edge(2'd3, 1'b0, 16'd6000);
		repeat (4) send_pulse(2'd2, epr_pkg::TS_W'($urandom), 16'd40000);
		send_pulse(2'd2, 16'hFFFF, 16'd100);
	endtask

	task automatic test_register_extremes();
		apply_settings(1023, 16383, 7, 0);
		send_pulse(2'd0, 16'd0, 16'd16399);
		send_pulse(2'd1, 16'd7, 16'd16400);
		send_pulse(2'd2, 16'hFFFF, 16'hFFFF);
		repeat (10) random_edge();
		apply_settings(0, 0, 0, 16383);
		send_pulse(2'd0, 16'd5, 16'd0);
		send_pulse(2'd3, 16'd9, 16'hFFFF);
		repeat (10) random_edge();
		apply_settings(0, 16383, 1, 0);
		repeat (10) random_edge();
		apply_settings(1, 1, 7, 16383);
		send_pulse(2'd1, 16'd0, 16'd1023);
		send_pulse(2'd1, 16'd0, 16'd1024);
		repeat (10) random_edge();
	endtask

	task automatic test_lowered_miss_limit();
		apply_settings(1023, 1, 7, 12345);
		repeat (5) send_pulse(2'd1, epr_pkg::TS_W'($urandom), 16'd50000);
		wait_idle();
		write_reg(epr_pkg::REG_MISS_LIMIT, epr_pkg::DIST_W'(2));
		send_pulse(2'd1, epr_pkg::TS_W'($urandom), 16'd50000);
		send_pulse(2'd1, epr_pkg::TS_W'($urandom), 16'd0);
		send_pulse(2'd1, epr_pkg::TS_W'($urandom), 16'd60000);
	endtask

	task automatic test_output_backpressure();
		apply_settings(int'(epr_pkg::SCALE_RST), int'(epr_pkg::RANGE_RST),
			int'(epr_pkg::MISS_RST), int'(epr_pkg::NO_OBJ_RST));
		tx_gaps = 0;
		rx_mode = RX_RANDOM;
		rx_hold_left = 300;
		repeat (40) send_pulse(epr_pkg::SENSOR_W'($urandom), epr_pkg::TS_W'($urandom),
			epr_pkg::TS_W'(pulse_width()));
		wait_idle();
		rx_hold_left = 120;
		repeat (60) random_edge();
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int scale;
		int lim_range;
		int miss_lim;
		int no_obj;
		for (int phase = 0; phase < 10; phase++) begin
			scale = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? 1023 : 0)
				: $urandom_range(1, 1023);
			lim_range = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? 16383 : 0)
				: $urandom_range(0, 16383);
			miss_lim = $urandom_range(0, 7);
			no_obj = ($urandom_range(0, 3) == 0) ? 16383 : $urandom_range(0, 16383);
			apply_settings(scale, lim_range, miss_lim, no_obj);
			tx_gaps = (phase % 3 != 0);
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			repeat (125) random_edge();
		end
	endtask

	initial begin
		errors = 0;
		edges_sent = 0;
		ranges_seen = 0;
		reg_writes = 0;
		hits_seen = 0;
		no_obj_seen = 0;
		burst_left = 0;
		tx_gaps = 0;
		rx_mode = RX_STEADY;
		rx_hold_left = 0;
		last_sensor = '0;
		cur_scale = epr_pkg::SCALE_RST;
		cur_range = epr_pkg::RANGE_RST;
		cur_miss_limit = epr_pkg::MISS_RST;
		cur_no_obj = epr_pkg::NO_OBJ_RST;
		for (int i = 0; i < epr_pkg::SENSORS; i++) begin
			start_ts[i] = '0;
			start_open[i] = 1'b0;
			miss_run[i] = '0;
			held_dist[i] = '0;
		end
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= epr_pkg::REG_SCALE_FACTOR;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_register_extremes();
		test_lowered_miss_limit();
		test_output_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Run covered %0d edge transactions, %0d range results",
			edges_sent, ranges_seen);
		$display("(%0d in range, %0d no object), %0d register writes, stalls; %0d mismatches.",
			hits_seen, no_obj_seen, reg_writes, errors);
		if (errors == 0 && pending_ranges.size() == 0)
			$display("[echo_pulse_ranger_top] OK");
		else
			$display("[echo_pulse_ranger_top] ERROR");
		$finish;
	end

endmodule

>>> echo_pulse_ranger_top.f
hdl/epr_pkg.sv
hdl/echo_pulse_ranger_top.sv
verif/tb_top.sv
